@@ hw/rtl/fla_pkg.sv @@
// shared types and constants of the free list block allocator
package fla_pkg;

   localparam int ADDR_W     = 16;
   localparam int SIZE_W     = 16;
   localparam int ALIGN_W    = 13;
   localparam int PAD_W      = 13;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;
   localparam int MIN_ALIGN  = 8;

   localparam logic [ADDR_W-1:0] REGION_RESET = 16'hFFFF;

   localparam int DEF_MAX_SEGMENTS = 16;
   localparam int DEF_MAX_ALLOCS   = 16;
   localparam int DEF_HEADER_BYTES = 16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_FREE    = 2'd1,
      FUNC_CLEAR   = 2'd2,
      FUNC_INVALID = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 3'd0,
      STAT_NO_FIT  = 3'd1,
      STAT_UNKNOWN = 3'd2,
      STAT_FULL    = 3'd3,
      STAT_BAD     = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIT_POLICY   = 8'd0,
      CSR_REGION_BYTES = 8'd1
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_SLOT, ST_PAD, ST_FIT, ST_TAKE,
      ST_FIND, ST_POS, ST_FREE, ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      SEG_HOLD, SEG_LOAD, SEG_REMOVE, SEG_INSERT, SEG_MERGE
   } seg_op_type;

   typedef enum logic [1:0] {
      ALC_HOLD, ALC_WRITE, ALC_DROP, ALC_DROP_ALL
   } alloc_op_type;

   typedef struct packed {
      seg_op_type        op;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] len;
   } seg_cmd_type;

   typedef struct packed {
      alloc_op_type      op;
      logic [ADDR_W-1:0] off;
      logic [ADDR_W-1:0] len;
      logic [PAD_W-1:0]  pad;
   } alloc_cmd_type;

endpackage

@@ hw/rtl/fla_seg_cell.sv @@
// one free segment cell of the address sorted segment chain
module fla_seg_cell #(
   parameter int IDX_W    = 4,
   parameter int CELL_IDX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fla_pkg::seg_cmd_type        cmd,
   input  logic [IDX_W-1:0]            cmd_idx,
   input  logic [fla_pkg::ADDR_W-1:0]  left_base,
   input  logic [fla_pkg::ADDR_W-1:0]  left_len,
   input  logic [fla_pkg::ADDR_W-1:0]  right_base,
   input  logic [fla_pkg::ADDR_W-1:0]  right_len,
   output logic [fla_pkg::ADDR_W-1:0]  base,
   output logic [fla_pkg::ADDR_W-1:0]  len
);
   import fla_pkg::*;

   localparam logic [IDX_W:0] MyIdx = (IDX_W+1)'(CELL_IDX);

   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] len_ff, len_in;
   logic [IDX_W:0]    idx;

   assign idx = {1'b0, cmd_idx};

   always_comb begin
      base_in = base_ff;
      len_in  = len_ff;
      case (cmd.op)
         SEG_LOAD: begin
            if (MyIdx == idx) begin
               base_in = cmd.base;
               len_in  = cmd.len;
            end
         end
         SEG_REMOVE: begin
            if (MyIdx >= idx) begin
               base_in = right_base;
               len_in  = right_len;
            end
         end
         SEG_INSERT: begin
            if (MyIdx == idx) begin
               base_in = cmd.base;
               len_in  = cmd.len;
            end else if (MyIdx > idx) begin
               base_in = left_base;
               len_in  = left_len;
            end
         end
         SEG_MERGE: begin
            if (MyIdx + 1'b1 == idx) begin
               len_in = cmd.len;
            end else if (MyIdx >= idx) begin
               base_in = right_base;
               len_in  = right_len;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         len_ff  <= REGION_RESET;
      end else begin
         base_ff <= base_in;
         len_ff  <= len_in;
      end
   end

   assign base = base_ff;
   assign len  = len_ff;

endmodule

@@ hw/rtl/fla_alloc_cell.sv @@
// one allocation record cell
module fla_alloc_cell #(
   parameter int IDX_W    = 4,
   parameter int CELL_IDX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fla_pkg::alloc_cmd_type      cmd,
   input  logic [IDX_W-1:0]            cmd_idx,
   output logic                        valid,
   output logic [fla_pkg::ADDR_W-1:0]  off,
   output logic [fla_pkg::ADDR_W-1:0]  len,
   output logic [fla_pkg::PAD_W-1:0]   pad
);
   import fla_pkg::*;

   localparam logic [IDX_W:0] MyIdx = (IDX_W+1)'(CELL_IDX);

   logic              valid_ff, valid_in;
   logic [ADDR_W-1:0] off_ff, off_in;
   logic [ADDR_W-1:0] len_ff, len_in;
   logic [PAD_W-1:0]  pad_ff, pad_in;
   logic              hit;

   assign hit = (MyIdx == {1'b0, cmd_idx});

   always_comb begin
      valid_in = valid_ff;
      off_in   = off_ff;
      len_in   = len_ff;
      pad_in   = pad_ff;
      case (cmd.op)
         ALC_WRITE: begin
            if (hit) begin
               valid_in = 1'b1;
               off_in   = cmd.off;
               len_in   = cmd.len;
               pad_in   = cmd.pad;
            end
         end
         ALC_DROP: begin
            if (hit) begin
               valid_in = 1'b0;
            end
         end
         ALC_DROP_ALL: valid_in = 1'b0;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
      len_ff <= len_in;
      pad_ff <= pad_in;
   end

   assign valid = valid_ff;
   assign off   = off_ff;
   assign len   = len_ff;
   assign pad   = pad_ff;

endmodule

@@ hw/rtl/free_list_block_allocator_core.sv @@
// free list block allocator: segment cell chain, allocation cells and request sequencer
// an allocate scans the allocation cells for a free slot, then checks each segment for a fit
// and takes the picked one; a free finds its record, then its place in the segment chain
// one request at a time: a new request is accepted only once the response register has loaded
// a response that waits holds the sequencer in its last state
// reset (synchronous, active high) leaves one 65535 byte segment at 0, no allocations, zero usage
module free_list_block_allocator_core #(
   parameter int MAX_SEGMENTS = fla_pkg::DEF_MAX_SEGMENTS,
   parameter int MAX_ALLOCS   = fla_pkg::DEF_MAX_ALLOCS,
   parameter int HEADER_BYTES = fla_pkg::DEF_HEADER_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_size, align_bytes, block_address, zero fill
   input  logic [fla_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func
   input  logic [fla_pkg::FUNC_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, data_offset, used_bytes, peak_used, zero fill
   output logic [fla_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fla_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fla_pkg::CSR_DATA_W-1:0]    csr_data
);
   import fla_pkg::*;

   localparam int SIW  = $clog2(MAX_SEGMENTS);
   localparam int AIW  = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
   localparam int CW   = $clog2(MAX_SEGMENTS + 1);
   localparam int SW   = $clog2(((MAX_SEGMENTS > MAX_ALLOCS) ? MAX_SEGMENTS : MAX_ALLOCS) + 1);
   localparam logic [SW-1:0] LastAlloc = SW'(MAX_ALLOCS - 1);
   localparam logic [CW-1:0] SegMax    = CW'(MAX_SEGMENTS);

   state_type state_ff, state_in;

   logic              policy_ff;
   logic [ADDR_W-1:0] region_ff;

   logic [SIZE_W-1:0]  size_ff;
   logic [ALIGN_W-1:0] align_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               bad_req;

   logic [SW-1:0]     scan_ff;
   logic [CW-1:0]     count_ff;
   logic [AIW-1:0]    slot_ff;
   logic [PAD_W-1:0]  pad_ff;
   logic              picked_ff;
   logic [SIW-1:0]    pick_ff;
   logic [ADDR_W-1:0] pick_base_ff;
   logic [ADDR_W-1:0] best_rest_ff;
   logic [PAD_W-1:0]  pick_pad_ff;
   logic [ADDR_W-1:0] fbase_ff;
   logic [ADDR_W-1:0] flen_ff;
   logic              has_prev_ff;
   logic [ADDR_W-1:0] prev_base_ff, prev_len_ff;
   logic              has_next_ff;
   logic [ADDR_W-1:0] next_base_ff, next_len_ff;
   logic [SIW-1:0]    pos_ff;
   logic [ADDR_W-1:0] used_ff, peak_ff;
   status_type        status_ff;
   logic [ADDR_W-1:0] off_ff;
   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   seg_cmd_type    seg_cmd;
   logic [SIW-1:0] seg_idx;
   alloc_cmd_type  alc_cmd;
   logic [AIW-1:0] alc_idx;
   logic           rsp_load;

   logic [ADDR_W-1:0] cell_base [MAX_SEGMENTS];
   logic [ADDR_W-1:0] cell_len  [MAX_SEGMENTS];
   logic              alc_valid [MAX_ALLOCS];
   logic [ADDR_W-1:0] alc_off   [MAX_ALLOCS];
   logic [ADDR_W-1:0] alc_len   [MAX_ALLOCS];
   logic [PAD_W-1:0]  alc_pad   [MAX_ALLOCS];

   logic [ADDR_W-1:0] rd_base, rd_len;
   logic              rd_valid;
   logic [ADDR_W-1:0] rd_off, rd_alen;
   logic [PAD_W-1:0]  rd_pad;
   logic              scan_end;

   logic [PAD_W-1:0]  amask, p0;
   logic [PAD_W:0]    hneed, pad_wide;
   logic [PAD_W-1:0]  pad_calc;
   logic [SIZE_W:0]   req_need;
   logic              fits;
   logic [ADDR_W-1:0] rest;
   logic              take_it;
   logic [ADDR_W:0]   used_sum;
   logic              join_prev, join_next;

   function automatic logic [ADDR_W-1:0] req_need_pick(input logic [SIZE_W-1:0] s,
                                                       input logic [PAD_W-1:0] p);
      req_need_pick = s + ADDR_W'(p);
   endfunction

   // cell chains
   for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_seg
      fla_seg_cell #(.IDX_W(SIW), .CELL_IDX(g)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (seg_cmd),
         .cmd_idx    (seg_idx),
         .left_base  (cell_base[(g > 0) ? g - 1 : g]),
         .left_len   (cell_len[(g > 0) ? g - 1 : g]),
         .right_base (cell_base[(g < MAX_SEGMENTS - 1) ? g + 1 : g]),
         .right_len  (cell_len[(g < MAX_SEGMENTS - 1) ? g + 1 : g]),
         .base       (cell_base[g]),
         .len        (cell_len[g])
      );
   end

   for (genvar g = 0; g < MAX_ALLOCS; g++) begin : g_alc
      fla_alloc_cell #(.IDX_W(AIW), .CELL_IDX(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (alc_cmd),
         .cmd_idx (alc_idx),
         .valid   (alc_valid[g]),
         .off     (alc_off[g]),
         .len     (alc_len[g]),
         .pad     (alc_pad[g])
      );
   end

   assign rd_base  = cell_base[scan_ff[SIW-1:0]];
   assign rd_len   = cell_len[scan_ff[SIW-1:0]];
   assign rd_valid = alc_valid[scan_ff[AIW-1:0]];
   assign rd_off   = alc_off[scan_ff[AIW-1:0]];
   assign rd_alen  = alc_len[scan_ff[AIW-1:0]];
   assign rd_pad   = alc_pad[scan_ff[AIW-1:0]];
   assign scan_end = (scan_ff >= SW'(count_ff));

   // request checks
   assign bad_req = ({1'b0, req_tdata[15:0]} < 17'(HEADER_BYTES)) ||
                    (req_tdata[28:16] < ALIGN_W'(MIN_ALIGN)) ||
                    ((req_tdata[28:16] & (req_tdata[28:16] - 1'b1)) != '0);

   // padding for the segment under the scan pointer
   always_comb begin
      amask    = align_ff - 1'b1;
      p0       = (align_ff - (rd_base[PAD_W-1:0] & amask)) & amask;
      hneed    = (PAD_W+1)'(HEADER_BYTES) - {1'b0, p0};
      pad_wide = {1'b0, p0};
      if ({1'b0, p0} < (PAD_W+1)'(HEADER_BYTES)) begin
         pad_wide = {1'b0, p0} + ((hneed + {1'b0, amask}) & ~{1'b0, amask});
      end
      pad_calc = pad_wide[PAD_W-1:0];
   end

   assign req_need = {1'b0, size_ff} + (SIZE_W+1)'(pad_ff);
   assign fits     = ({1'b0, rd_len} >= req_need);
   assign rest     = rd_len - req_need[ADDR_W-1:0];
   assign take_it  = fits && (!picked_ff || (policy_ff && (rest < best_rest_ff)));
   assign used_sum = {1'b0, used_ff} + (ADDR_W+1)'(req_need_pick(size_ff, pick_pad_ff));

   assign join_prev = has_prev_ff &&
                      (({1'b0, prev_base_ff} + {1'b0, prev_len_ff}) == {1'b0, fbase_ff});
   assign join_next = has_next_ff &&
                      (({1'b0, fbase_ff} + {1'b0, flen_ff}) == {1'b0, next_base_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (func_type'(req_tuser))
                  FUNC_ALLOC:   state_in = bad_req ? ST_RESP : ST_SLOT;
                  FUNC_FREE:    state_in = ST_FIND;
                  FUNC_CLEAR:   state_in = ST_CLEAR;
                  default:      state_in = ST_RESP;
               endcase
            end
         end
         ST_CLEAR: state_in = ST_RESP;
         ST_SLOT: begin
            if (!rd_valid) begin
               state_in = ST_PAD;
            end else if (scan_ff == LastAlloc) begin
               state_in = ST_RESP;
            end
         end
         ST_PAD: begin
            if (scan_end) begin
               state_in = picked_ff ? ST_TAKE : ST_RESP;
            end else begin
               state_in = ST_FIT;
            end
         end
         ST_FIT: state_in = (fits && !policy_ff) ? ST_TAKE : ST_PAD;
         ST_TAKE: state_in = ST_RESP;
         ST_FIND: begin
            if (rd_valid && (rd_off == addr_ff)) begin
               state_in = ST_POS;
            end else if (scan_ff == LastAlloc) begin
               state_in = ST_RESP;
            end
         end
         ST_POS: begin
            if (scan_end || (rd_base > fbase_ff)) begin
               state_in = ST_FREE;
            end
         end
         ST_FREE: state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // cell commands and handshakes
   always_comb begin
      seg_cmd    = '{op: SEG_HOLD, base: '0, len: '0};
      seg_idx    = '0;
      alc_cmd    = '{op: ALC_HOLD, off: '0, len: '0, pad: '0};
      alc_idx    = slot_ff;
      rsp_load   = 1'b0;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_CLEAR: begin
            seg_cmd = '{op: SEG_LOAD, base: '0, len: region_ff};
            alc_cmd.op = ALC_DROP_ALL;
         end
         ST_TAKE: begin
            alc_cmd = '{op: ALC_WRITE, off: pick_base_ff + ADDR_W'(pick_pad_ff),
                        len: req_need_pick(size_ff, pick_pad_ff), pad: pick_pad_ff};
            seg_idx = pick_ff;
            if (best_rest_ff != '0) begin
               seg_cmd = '{op: SEG_LOAD,
                           base: pick_base_ff + req_need_pick(size_ff, pick_pad_ff),
                           len: best_rest_ff};
            end else begin
               seg_cmd.op = SEG_REMOVE;
            end
         end
         ST_FREE: begin
            seg_idx = pos_ff;
            if (join_prev && join_next) begin
               seg_cmd = '{op: SEG_MERGE, base: '0,
                           len: prev_len_ff + flen_ff + next_len_ff};
               alc_cmd.op = ALC_DROP;
            end else if (join_prev) begin
               seg_idx = pos_ff - 1'b1;
               seg_cmd = '{op: SEG_LOAD, base: prev_base_ff, len: prev_len_ff + flen_ff};
               alc_cmd.op = ALC_DROP;
            end else if (join_next) begin
               seg_cmd = '{op: SEG_LOAD, base: fbase_ff, len: flen_ff + next_len_ff};
               alc_cmd.op = ALC_DROP;
            end else if (count_ff < SegMax) begin
               seg_cmd = '{op: SEG_INSERT, base: fbase_ff, len: flen_ff};
               alc_cmd.op = ALC_DROP;
            end
         end
         ST_RESP: rsp_load = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         policy_ff <= 1'b0;
         region_ff <= REGION_RESET;
         count_ff  <= CW'(1);
         used_ff   <= '0;
         peak_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_reg_type'(csr_index))
               CSR_FIT_POLICY:   policy_ff <= csr_data[0];
               CSR_REGION_BYTES: region_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (state_ff == ST_CLEAR) begin
            count_ff <= CW'(1);
            used_ff  <= '0;
            peak_ff  <= '0;
         end
         if (state_ff == ST_TAKE) begin
            if (best_rest_ff == '0) begin
               count_ff <= count_ff - 1'b1;
            end
            used_ff <= used_sum[ADDR_W-1:0];
            if (used_sum[ADDR_W-1:0] > peak_ff) begin
               peak_ff <= used_sum[ADDR_W-1:0];
            end
         end
         if (state_ff == ST_FREE && (join_prev || join_next || count_ff < SegMax)) begin
            if (join_prev && join_next) begin
               count_ff <= count_ff - 1'b1;
            end else if (!join_prev && !join_next) begin
               count_ff <= count_ff + 1'b1;
            end
            used_ff <= used_ff - flen_ff;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            size_ff   <= req_tdata[15:0];
            align_ff  <= req_tdata[28:16];
            addr_ff   <= req_tdata[44:29];
            scan_ff   <= '0;
            picked_ff <= 1'b0;
            off_ff    <= '0;
            has_prev_ff <= 1'b0;
            has_next_ff <= 1'b0;
            status_ff <= (func_type'(req_tuser) == FUNC_INVALID ||
                          (func_type'(req_tuser) == FUNC_ALLOC && bad_req)) ? STAT_BAD : STAT_OK;
         end
         ST_SLOT: begin
            if (!rd_valid) begin
               slot_ff <= scan_ff[AIW-1:0];
               scan_ff <= '0;
            end else if (scan_ff == LastAlloc) begin
               status_ff <= STAT_FULL;
            end else begin
               scan_ff <= scan_ff + 1'b1;
            end
         end
         ST_PAD: begin
            pad_ff <= pad_calc;
            if (scan_end && !picked_ff) begin
               status_ff <= STAT_NO_FIT;
            end
         end
         ST_FIT: begin
            if (take_it) begin
               picked_ff    <= 1'b1;
               pick_ff      <= scan_ff[SIW-1:0];
               pick_base_ff <= rd_base;
               best_rest_ff <= rest;
               pick_pad_ff  <= pad_ff;
            end
            scan_ff <= scan_ff + 1'b1;
         end
         ST_TAKE: off_ff <= pick_base_ff + ADDR_W'(pick_pad_ff);
         ST_FIND: begin
            if (rd_valid && (rd_off == addr_ff)) begin
               slot_ff  <= scan_ff[AIW-1:0];
               fbase_ff <= rd_off - ADDR_W'(rd_pad);
               flen_ff  <= rd_alen;
               scan_ff  <= '0;
            end else if (scan_ff == LastAlloc) begin
               status_ff <= STAT_UNKNOWN;
            end else begin
               scan_ff <= scan_ff + 1'b1;
            end
         end
         ST_POS: begin
            if (scan_end) begin
               pos_ff <= scan_ff[SIW-1:0];
            end else if (rd_base > fbase_ff) begin
               pos_ff       <= scan_ff[SIW-1:0];
               has_next_ff  <= 1'b1;
               next_base_ff <= rd_base;
               next_len_ff  <= rd_len;
            end else begin
               has_prev_ff  <= 1'b1;
               prev_base_ff <= rd_base;
               prev_len_ff  <= rd_len;
               scan_ff      <= scan_ff + 1'b1;
            end
         end
         ST_FREE: begin
            if (!join_prev && !join_next && count_ff >= SegMax) begin
               status_ff <= STAT_FULL;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {5'd0, peak_ff, used_ff, off_ff, status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule
